### hdl/sit_pkg.sv
package sit_pkg;

	// Default coordinate width of the input fields.
	localparam int COORD_BITS_DEF = 16;

	// Products formed per item, and the cross terms made from pairs of them.
	localparam int NUM_PROD  = 8;
	localparam int NUM_CROSS = NUM_PROD / 2;

	// Which rule decides the item.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_VERT,
		KIND_LINE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  overlap;
	} flags_t;

endpackage

### hdl/segment_intersection_test.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// in       | in_valid / in_ready   | a_start_x .. b_end_y, COORD_BITS each
// out      | out_valid / out_ready | intersects
//
// Five register stages: setup, operand selection, multiply, cross terms, decision.
// One transfer per cycle in each direction while out_ready is held high.
// arst_n clears only the stage valid bits; the data registers are not reset.
// A stage loads whenever it is empty or its successor loads, so bubbles close up
// under a stalled output and nothing is dropped or repeated.
module segment_intersection_test import sit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         intersects
);

	localparam int DW = COORD_BITS + 1;
	localparam int XW = 2 * DW + 1;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [DW-1:0] opa_s2   [NUM_PROD];
	logic signed [DW-1:0] opb_s2   [NUM_PROD];
	logic signed [XW-1:0] cross_s4 [NUM_CROSS];
	flags_t               flags_s2, flags_s4;

	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	sit_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.clk       (clk),
		.en_s1     (en_s1),
		.en_s2     (en_s2),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.opa_s2    (opa_s2),
		.opb_s2    (opb_s2),
		.flags_s2  (flags_s2)
	);

	sit_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk      (clk),
		.en_s3    (en_s3),
		.en_s4    (en_s4),
		.opa_s2   (opa_s2),
		.opb_s2   (opb_s2),
		.flags_s2 (flags_s2),
		.cross_s4 (cross_s4),
		.flags_s4 (flags_s4)
	);

	sit_decide #(
		.COORD_BITS(COORD_BITS)
	) u_decide (
		.clk           (clk),
		.en_s5         (en_s5),
		.cross_s4      (cross_s4),
		.flags_s4      (flags_s4),
		.intersects_s5 (intersects)
	);

endmodule

### hdl/sit_setup.sv
module sit_setup import sit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en_s1,
	input  logic                         en_s2,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	output logic signed [COORD_BITS:0]   opa_s2 [NUM_PROD],
	output logic signed [COORD_BITS:0]   opb_s2 [NUM_PROD],
	output flags_t                       flags_s2
);

	localparam int CW = COORD_BITS;
	localparam int DW = COORD_BITS + 1;

	// Stage 1: classify, exchange axes for two vertical segments, pick the vertical one.
	logic  a_point, b_point, a_vert, b_vert, swap_xy;
	kind_t kind;

	logic signed [CW-1:0] gax1_s1, gay1_s1, gax2_s1, gay2_s1;
	logic signed [CW-1:0] gbx1_s1, gby1_s1, gbx2_s1, gby2_s1;
	logic signed [CW-1:0] vx_s1, vy1_s1, vy2_s1, px1_s1, py1_s1, px2_s1, py2_s1;
	kind_t                kind_s1;

	always_comb begin
		a_point = (a_start_x == a_end_x) && (a_start_y == a_end_y);
		b_point = (b_start_x == b_end_x) && (b_start_y == b_end_y);
		a_vert  = (a_start_x == a_end_x);
		b_vert  = (b_start_x == b_end_x);
		swap_xy = a_vert && b_vert;
		priority if (a_point || b_point) begin
			kind = KIND_NONE;
		end else if (a_vert != b_vert) begin
			kind = KIND_VERT;
		end else begin
			kind = KIND_LINE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			gax1_s1 <= swap_xy ? a_start_y : a_start_x;
			gay1_s1 <= swap_xy ? a_start_x : a_start_y;
			gax2_s1 <= swap_xy ? a_end_y   : a_end_x;
			gay2_s1 <= swap_xy ? a_end_x   : a_end_y;
			gbx1_s1 <= swap_xy ? b_start_y : b_start_x;
			gby1_s1 <= swap_xy ? b_start_x : b_start_y;
			gbx2_s1 <= swap_xy ? b_end_y   : b_end_x;
			gby2_s1 <= swap_xy ? b_end_x   : b_end_y;
			vx_s1   <= a_vert ? a_start_x : b_start_x;
			vy1_s1  <= a_vert ? a_start_y : b_start_y;
			vy2_s1  <= a_vert ? a_end_y   : b_end_y;
			px1_s1  <= a_vert ? b_start_x : a_start_x;
			py1_s1  <= a_vert ? b_start_y : a_start_y;
			px2_s1  <= a_vert ? b_end_x   : a_end_x;
			py2_s1  <= a_vert ? b_end_y   : a_end_y;
			kind_s1 <= kind;
		end
	end

	// Stage 2: differences, ordering and range tests, then the multiplier operands.
	logic signed [DW-1:0] d1x, d1y, d2x, d2y, wx, wy;
	logic signed [CW-1:0] qx1, qy1, qx2, qy2, vlo, vhi;
	logic signed [CW-1:0] alo, ahi, blo, bhi;
	logic signed [DW-1:0] dx, dy, nvx, plo, phi;
	logic                 swap_p, in_range, overlap;

	always_comb begin
		d1x = DW'(gax2_s1) - DW'(gax1_s1);
		d1y = DW'(gay2_s1) - DW'(gay1_s1);
		d2x = DW'(gbx2_s1) - DW'(gbx1_s1);
		d2y = DW'(gby2_s1) - DW'(gby1_s1);
		wx  = DW'(gbx1_s1) - DW'(gax1_s1);
		wy  = DW'(gby1_s1) - DW'(gay1_s1);

		// The other segment is walked from its lower x end.
		swap_p   = px1_s1 > px2_s1;
		qx1      = swap_p ? px2_s1 : px1_s1;
		qy1      = swap_p ? py2_s1 : py1_s1;
		qx2      = swap_p ? px1_s1 : px2_s1;
		qy2      = swap_p ? py1_s1 : py2_s1;
		vlo      = (vy1_s1 < vy2_s1) ? vy1_s1 : vy2_s1;
		vhi      = (vy1_s1 < vy2_s1) ? vy2_s1 : vy1_s1;
		in_range = (qx1 <= vx_s1) && (vx_s1 <= qx2);
		dx       = DW'(qx2) - DW'(qx1);
		dy       = DW'(qy2) - DW'(qy1);
		nvx      = DW'(qx1) - DW'(vx_s1);
		plo      = DW'(qy1) - DW'(vlo);
		phi      = DW'(qy1) - DW'(vhi);

		alo     = (gax1_s1 < gax2_s1) ? gax1_s1 : gax2_s1;
		ahi     = (gax1_s1 < gax2_s1) ? gax2_s1 : gax1_s1;
		blo     = (gbx1_s1 < gbx2_s1) ? gbx1_s1 : gbx2_s1;
		bhi     = (gbx1_s1 < gbx2_s1) ? gbx2_s1 : gbx1_s1;
		overlap = (alo < blo) ? (blo < ahi) : (alo < bhi);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			if (kind_s1 == KIND_VERT) begin
				// Both bounds as (y1 - bound) * dx + dy * (vx - x1).
				opa_s2[0] <= plo; opb_s2[0] <= dx;
				opa_s2[1] <= dy;  opb_s2[1] <= nvx;
				opa_s2[2] <= phi; opb_s2[2] <= dx;
				opa_s2[3] <= dy;  opb_s2[3] <= nvx;
				for (int i = 4; i < NUM_PROD; i++) begin
					opa_s2[i] <= '0;
					opb_s2[i] <= '0;
				end
			end else begin
				opa_s2[0] <= d1x; opb_s2[0] <= d2y;
				opa_s2[1] <= d1y; opb_s2[1] <= d2x;
				opa_s2[2] <= d1x; opb_s2[2] <= wy;
				opa_s2[3] <= d1y; opb_s2[3] <= wx;
				opa_s2[4] <= wx;  opb_s2[4] <= d2y;
				opa_s2[5] <= wy;  opb_s2[5] <= d2x;
				opa_s2[6] <= wx;  opb_s2[6] <= d1y;
				opa_s2[7] <= wy;  opb_s2[7] <= d1x;
			end
			flags_s2.kind     <= kind_s1;
			flags_s2.in_range <= in_range;
			flags_s2.overlap  <= overlap;
		end
	end

endmodule

### hdl/sit_cross.sv
module sit_cross import sit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en_s3,
	input  logic                             en_s4,
	input  logic signed [COORD_BITS:0]       opa_s2 [NUM_PROD],
	input  logic signed [COORD_BITS:0]       opb_s2 [NUM_PROD],
	input  flags_t                           flags_s2,
	output logic signed [2*COORD_BITS+2:0]   cross_s4 [NUM_CROSS],
	output flags_t                           flags_s4
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;

	logic signed [PW-1:0] prod_s3 [NUM_PROD];
	flags_t               flags_s3;

	// Stage 3: one signed multiplier per product.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < NUM_PROD; i++) begin
				prod_s3[i] <= PW'(opa_s2[i]) * PW'(opb_s2[i]);
			end
			flags_s3 <= flags_s2;
		end
	end

	// Stage 4: each cross term is the difference of a product pair.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int j = 0; j < NUM_CROSS; j++) begin
				cross_s4[j] <= XW'(prod_s3[2*j]) - XW'(prod_s3[2*j+1]);
			end
			flags_s4 <= flags_s3;
		end
	end

endmodule

### hdl/sit_decide.sv
module sit_decide import sit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en_s5,
	input  logic signed [2*COORD_BITS+2:0] cross_s4 [NUM_CROSS],
	input  flags_t                         flags_s4,
	output logic                           intersects_s5
);

	localparam int XW = 2 * (COORD_BITS + 1) + 1;
	localparam int EW = XW + 1;

	logic signed [XW-1:0] den, col, n1, n2;
	logic signed [EW-1:0] e1, e2;
	logic                 den_zero, den_neg, n1_ok, n2_ok, e1_ok, e2_ok;
	logic                 line_hit, vert_hit, hit;

	always_comb begin
		// In the vertical case only the first two terms are used: the lower and
		// upper y bound tests.
		den = cross_s4[0];
		col = cross_s4[1];
		n1  = cross_s4[2];
		n2  = cross_s4[3];
		e1  = EW'(den) - EW'(n1);
		e2  = EW'(den) - EW'(n2);

		den_zero = (den == '0);
		den_neg  = den[XW-1];
		// A ratio strictly inside (0, 1): numerator and den minus numerator
		// both nonzero with the sign of den.
		n1_ok = (n1 != '0) && (n1[XW-1] == den_neg);
		n2_ok = (n2 != '0) && (n2[XW-1] == den_neg);
		e1_ok = (e1 != '0) && (e1[EW-1] == den_neg);
		e2_ok = (e2 != '0) && (e2[EW-1] == den_neg);

		line_hit = den_zero ? ((col == '0) && flags_s4.overlap)
		                    : (n1_ok && e1_ok && n2_ok && e2_ok);
		vert_hit = flags_s4.in_range && !den[XW-1] && (col[XW-1] || (col == '0));

		unique case (flags_s4.kind)
			KIND_VERT: hit = vert_hit;
			KIND_LINE: hit = line_hit;
			default:   hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			intersects_s5 <= hit;
		end
	end

endmodule
